/* hdl/base64_stream_encoder_assert.svh */
// assertion macros shared by the encoder modules
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define B64E_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define B64E_ASSERT(lbl, prop, msg)
`define B64E_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/b64e_pkg.sv */
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [6:0] CHAR_PAD   = 7'd61;
   localparam logic [6:0] CHAR_PLUS  = 7'd43;
   localparam logic [6:0] CHAR_SLASH = 7'd47;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       out_last;
   } rsp_type;

   // one group ready for emission: have counts the alphabet characters minus one
   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  have;
      logic        last;
   } grp_type;

   typedef struct packed {
      logic    push;
      grp_type grp;
   } grp_push_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] idx);
      logic [6:0] ch;
      case (idx) inside
         [6'd0:6'd25]:  ch = 7'(idx) + 7'd65;
         [6'd26:6'd51]: ch = 7'(idx) + 7'd71;
         [6'd52:6'd61]: ch = 7'(idx) - 7'd4;
         6'd62:         ch = CHAR_PLUS;
         default:       ch = CHAR_SLASH;
      endcase
      return ch;
   endfunction

endpackage

/* hdl/b64e_front.sv */
`include "base64_stream_encoder_assert.svh"

module b64e_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  b64e_pkg::req_type     req_data,
   input  logic                  q_full,
   output logic                  accept,
   output b64e_pkg::grp_push_type q_wr
);

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic [1:0]  have;
   logic        emit;

   assign accept = req_push && !q_full;

   always_comb begin
      have = (held_count_ff == 2'd0) ? 2'd1 : (held_count_ff == 2'd1) ? 2'd2 : 2'd3;
      case (held_count_ff)
         2'd0:    held_bytes_in = {req_data.data_byte, 8'h00};
         2'd1:    held_bytes_in = {held_bytes_ff[15:8], req_data.data_byte};
         default: held_bytes_in = held_bytes_ff;
      endcase
      emit = (have == 2'd3) || req_data.last_byte;
      held_count_in = emit ? 2'd0 : have;

      q_wr.push      = accept && emit;
      q_wr.grp.have  = have;
      q_wr.grp.last  = req_data.last_byte;
      q_wr.grp.group = (have == 2'd3) ? {held_bytes_ff, req_data.data_byte}
                                      : {held_bytes_in, 8'h00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_count_ff <= '0;
      end else if (accept) begin
         held_bytes_ff <= emit ? 16'h0000 : held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

   `B64E_ASSERT(a_count_range, held_count_ff != 2'd3, "group count reached three")
   `B64E_ASSERT(a_gather, accept && !req_data.last_byte && held_count_ff == 2'd0 |=> held_count_ff == 2'd1, "first byte of group not held")

endmodule

/* hdl/b64e_fifo.sv */
`include "base64_stream_encoder_assert.svh"

module b64e_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  b64e_pkg::grp_push_type wr,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output b64e_pkg::grp_type      rd_data
);

   b64e_pkg::grp_type           mem_ff [b64e_pkg::QUEUE_DEPTH];
   logic [b64e_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [b64e_pkg::QUEUE_AW:0]   count_ff;
   logic                          do_push, do_pop;

   assign full    = (count_ff == (b64e_pkg::QUEUE_AW+1)'(b64e_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = wr.push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr.grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == (b64e_pkg::QUEUE_AW)'(b64e_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == (b64e_pkg::QUEUE_AW)'(b64e_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `B64E_ASSERT(a_no_overflow, count_ff <= (b64e_pkg::QUEUE_AW+1)'(b64e_pkg::QUEUE_DEPTH), "group queue overfilled")
   `B64E_ASSERT(a_push_dropped, wr.push |-> !full, "group pushed into full queue")

endmodule

/* hdl/b64e_back.sv */
`include "base64_stream_encoder_assert.svh"

module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  b64e_pkg::grp_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output b64e_pkg::rsp_type rsp_data
);

   b64e_pkg::grp_type cur_ff;
   logic [1:0]        slot_ff;
   logic              busy_ff;
   b64e_pkg::rsp_type out_ff, out_in;
   logic              out_valid_ff;
   logic              out_free, take, fetch;
   logic [5:0]        sextet;

   assign out_free = !out_valid_ff || rsp_pop;
   assign take     = busy_ff && out_free;
   // next group is fetched as the fourth character of the current one leaves
   assign fetch    = !q_empty && (!busy_ff || (take && slot_ff == 2'd3));
   assign q_pop    = fetch;

   always_comb begin
      case (slot_ff)
         2'd0:    sextet = cur_ff.group[23:18];
         2'd1:    sextet = cur_ff.group[17:12];
         2'd2:    sextet = cur_ff.group[11:6];
         default: sextet = cur_ff.group[5:0];
      endcase
      out_in.out_char = (slot_ff <= cur_ff.have) ? b64e_pkg::sextet_char(sextet)
                                                 : b64e_pkg::CHAR_PAD;
      out_in.out_last = (slot_ff == 2'd3) && cur_ff.last;
   end

   always_ff @(posedge clock) begin
      if (fetch) begin
         cur_ff <= q_data;
      end
      if (take) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            out_valid_ff <= 1'b1;
            slot_ff      <= slot_ff + 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         if (fetch) begin
            busy_ff <= 1'b1;
            slot_ff <= '0;
         end else if (take && slot_ff == 2'd3) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   `B64E_ASSERT(a_idle_slot, !busy_ff |-> slot_ff == 2'd0, "slot not rewound while idle")
   `B64E_ASSERT(a_last_slot, take && slot_ff != 2'd3 |=> !out_ff.out_last, "end flag on early character")

endmodule

/* hdl/base64_stream_encoder.sv */
// channel   ports                          direction  word
// request   req_push req_full req_data     in         one byte, last-of-message flag
// response  rsp_pop rsp_empty rsp_data     out        one character, last-character flag
//
// one byte is taken per cycle while the group queue has room
// each group of bytes leaves as four characters, one per cycle from the output register while rsp_pop is held
// sustained rate is set by the character emitter: four characters per group of up to three bytes
// synchronous reset empties the group queue and drops any partial group
// a stalled response side fills the two-group queue and then raises req_full
module base64_stream_encoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  b64e_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output b64e_pkg::rsp_type rsp_data
);

   b64e_pkg::grp_push_type q_wr;
   b64e_pkg::grp_type      q_rd;
   logic                   q_full, q_empty, q_pop, accept;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .q_full   (q_full),
      .accept   (accept),
      .q_wr     (q_wr)
   );

   b64e_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr      (q_wr),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .rd_data (q_rd)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign req_full = q_full;

   `include "base64_stream_encoder_assert.svh"

   `B64E_ASSERT(a_accept, accept == (req_push && !req_full), "byte take disagrees with handshake")

endmodule

/* sim/tb_base64_stream_encoder.sv */
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASE_WORDS    = 45;
   localparam int TAIL_CYCLES    = 16;

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [31:0] text;
   } dir_row_type;

   // typed rows carry the four characters that the closing byte must produce
   localparam dir_row_type DIRECTED [0:23] = '{
      '{8'h00, 1'b0, 1'b0, "----"}, '{8'h00, 1'b0, 1'b0, "----"},
      '{8'h00, 1'b0, 1'b1, "AAAA"},
      '{8'hFF, 1'b0, 1'b0, "----"}, '{8'hFF, 1'b0, 1'b0, "----"},
      '{8'hFF, 1'b1, 1'b1, "////"},
      '{8'h4D, 1'b0, 1'b0, "----"}, '{8'h61, 1'b0, 1'b0, "----"},
      '{8'h6E, 1'b0, 1'b1, "TWFu"},
      '{8'h4D, 1'b1, 1'b1, "TQ=="},
      '{8'h4D, 1'b0, 1'b0, "----"}, '{8'h61, 1'b1, 1'b1, "TWE="},
      '{8'hFF, 1'b1, 1'b1, "/w=="},
      '{8'h00, 1'b1, 1'b1, "AA=="},
      '{8'hFF, 1'b0, 1'b0, "----"}, '{8'hFF, 1'b1, 1'b1, "//8="},
      '{8'h00, 1'b0, 1'b0, "----"}, '{8'h00, 1'b1, 1'b1, "AAA="},
      '{8'hFB, 1'b0, 1'b0, "----"}, '{8'hEF, 1'b0, 1'b0, "----"},
      '{8'hBE, 1'b1, 1'b1, "++++"},
      '{8'h80, 1'b0, 1'b0, "----"}, '{8'h01, 1'b0, 1'b0, "----"},
      '{8'h7F, 1'b0, 1'b0, "----"}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   b64e_pkg::req_type req_data  = '0;
   logic              rsp_pop   = 1'b0;
   logic              req_full;
   logic              rsp_empty;
   b64e_pkg::rsp_type rsp_data;

   // encoder state as predicted
   logic [15:0] held_bytes = '0;
   logic [1:0]  held_count = '0;

   b64e_pkg::rsp_type char_queue [$];
   int          tx_idle_pct = 38;
   int          rx_idle_pct = 78;
   int unsigned errors      = 0;
   int unsigned stall_cycles = 0;
   int unsigned hold_asked  = 0;
   int unsigned hold_taken  = 0;
   int unsigned hold_left   = 0;

   base64_stream_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [6:0] alphabet_char(input logic [5:0] idx);
      return ALPHABET[8*(63 - int'(idx)) +: 7];
   endfunction

   // gathers one byte, returns the number of characters it releases
   function automatic int encode_byte(input b64e_pkg::req_type w,
                                      output b64e_pkg::rsp_type chars [4]);
      logic [23:0] group;
      int          have;
      if (held_count == 2'd0) begin
         held_bytes = {w.data_byte, 8'h00};
      end else if (held_count == 2'd1) begin
         held_bytes[7:0] = w.data_byte;
      end
      have = (held_count > 2'd1) ? 3 : int'(held_count) + 1;
      if (have < 3 && !w.last_byte) begin
         held_count = 2'(have);
         return 0;
      end
      group = (have == 3) ? {held_bytes, w.data_byte} : {held_bytes, 8'h00};
      for (int k = 0; k < 4; k++) begin
         chars[k].out_char = (k <= have) ? alphabet_char(group[18 - 6*k +: 6])
                                         : b64e_pkg::CHAR_PAD;
         chars[k].out_last = (k == 3) && w.last_byte;
      end
      held_bytes = '0;
      held_count = '0;
      return 4;
   endfunction

   task automatic send_word(input b64e_pkg::req_type w, input logic typed,
                            input logic [31:0] text);
      b64e_pkg::rsp_type chars [4];
      int                n;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      n = encode_byte(w, chars);
      if (typed) begin
         for (int k = 0; k < 4; k++) begin
            chars[k].out_char = text[8*(3 - k) +: 7];
            chars[k].out_last = (k == 3) && w.last_byte;
         end
      end
      for (int k = 0; k < n; k++) char_queue.push_back(chars[k]);
   endtask

   task automatic send_messages(input int words);
      b64e_pkg::req_type w;
      int                len;
      int                sent;
      sent = 0;
      while (sent < words) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(9))
               0:       w.data_byte = 8'h00;
               1:       w.data_byte = 8'hFF;
               default: w.data_byte = 8'($urandom_range(255));
            endcase
            w.last_byte = (i == len - 1);
            send_word(w, 1'b0, '0);
         end
         sent += len;
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (char_queue.size() != 0) @(posedge clock);
   endtask

   // receiving side: checks each popped word, then decides the next pop
   always @(posedge clock) begin : rx_side
      b64e_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (char_queue.size() == 0) begin
               $error("unexpected character %0d", rsp_data.out_char);
               errors++;
            end else begin
               want = char_queue.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  $error("out_char expected %0d actual %0d", want.out_char, rsp_data.out_char);
                  errors++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last expected %0d actual %0d", want.out_last, rsp_data.out_last);
                  errors++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_taken + 1;
            hold_left  <= HOLD_CYCLES;
            rsp_pop    <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("base64_stream_encoder regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < 24; r++) begin
         send_word('{data_byte: DIRECTED[r].data, last_byte: DIRECTED[r].last},
                   DIRECTED[r].typed, DIRECTED[r].text);
      end
      send_messages(PHASE_WORDS);

      // sender waits for every outstanding character
      wait_drained();
      tx_idle_pct = 78;
      rx_idle_pct = 38;
      send_messages(PHASE_WORDS);

      // long receiver hold-off while words keep coming, so the queue backs up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_asked <= hold_asked + 1;
      send_messages(PHASE_WORDS);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("base64_stream_encoder regression: pass");
      end else begin
         $display("base64_stream_encoder regression: fail");
      end
      $finish;
   end

endmodule
